// ===== src/bld_pkg.sv =====
// Package for the binary long division unit.
// Holds the default operand width; no dependencies.

package bld_pkg;

  localparam int unsigned DataWidthDefault = 32;

endpackage

// ===== src/bld_stage.sv =====
// One restoring shift-subtract step of the divider pipeline, with its registers.
// Depends on bld_pkg.

module bld_stage
  import bld_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DataWidth-1:0] qn_i,
  input  logic [DataWidth-1:0] rem_i,
  input  logic [DataWidth-1:0] den_i,
  input  logic                 dbz_i,
  output logic                 valid_o,
  output logic [DataWidth-1:0] qn_o,
  output logic [DataWidth-1:0] rem_o,
  output logic [DataWidth-1:0] den_o,
  output logic                 dbz_o
);

  logic                 valid_q;
  logic [DataWidth-1:0] qn_q, qn_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] den_q;
  logic                 dbz_q;

  logic [DataWidth-1:0] shifted;
  logic [DataWidth:0]   diff;
  logic                 fits;

  // qn holds the unconsumed dividend bits on top and the quotient bits below.
  always_comb begin
    shifted = {rem_i[DataWidth-2:0], qn_i[DataWidth-1]};
    diff    = {rem_i[DataWidth-1], shifted} - {1'b0, den_i};
    // With the carry bit set the difference is always positive.
    fits    = ~diff[DataWidth];
    rem_d   = fits ? diff[DataWidth-1:0] : shifted;
    qn_d    = {qn_i[DataWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qn_q  <= qn_d;
      rem_q <= rem_d;
      den_q <= den_i;
      dbz_q <= dbz_i;
    end
  end

  assign valid_o = valid_q;
  assign qn_o    = qn_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign dbz_o   = dbz_q;

endmodule

// ===== src/binary_long_division_unit.sv =====
// Top level of the pipelined unsigned binary long division unit.
// Depends on bld_pkg and bld_stage.

// Unsigned divider, one quotient bit per pipeline stage: DataWidth stages of
// one shift, compare and subtract each. It takes a new request every cycle as
// long as the output is not stalled, and each result passes through every
// stage register in order; a stall on a valid result freezes the whole pipeline and
// is passed straight back to the input. A zero divisor raises divide_by_zero_o,
// with an all-ones quotient and the dividend as remainder.

module binary_long_division_unit
  import bld_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [DataWidth-1:0] quotient_o,
  output logic [DataWidth-1:0] remainder_o,
  output logic                 divide_by_zero_o
);

  logic                 valid_s [0:DataWidth];
  logic [DataWidth-1:0] qn_s    [0:DataWidth];
  logic [DataWidth-1:0] rem_s   [0:DataWidth];
  logic [DataWidth-1:0] den_s   [0:DataWidth-1];
  logic                 dbz_s   [0:DataWidth];
  logic                 adv;

  assign adv     = ~(valid_s[DataWidth] & stall_i);
  assign stall_o = ~adv;

  assign valid_s[0] = valid_i;
  assign qn_s[0]    = dividend_i;
  assign rem_s[0]   = '0;
  assign den_s[0]   = divisor_i;
  assign dbz_s[0]   = (divisor_i == '0);

  for (genvar k = 0; k < DataWidth; k++) begin : g_stage
    if (k < DataWidth - 1) begin : g_mid
      bld_stage #(
        .DataWidth(DataWidth)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .valid_i(valid_s[k]),
        .qn_i   (qn_s[k]),
        .rem_i  (rem_s[k]),
        .den_i  (den_s[k]),
        .dbz_i  (dbz_s[k]),
        .valid_o(valid_s[k+1]),
        .qn_o   (qn_s[k+1]),
        .rem_o  (rem_s[k+1]),
        .den_o  (den_s[k+1]),
        .dbz_o  (dbz_s[k+1])
      );
    end else begin : g_last
      // The divisor is not needed past the last step.
      bld_stage #(
        .DataWidth(DataWidth)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .valid_i(valid_s[k]),
        .qn_i   (qn_s[k]),
        .rem_i  (rem_s[k]),
        .den_i  (den_s[k]),
        .dbz_i  (dbz_s[k]),
        .valid_o(valid_s[k+1]),
        .qn_o   (qn_s[k+1]),
        .rem_o  (rem_s[k+1]),
        .den_o  (),
        .dbz_o  (dbz_s[k+1])
      );
    end
  end

  assign valid_o          = valid_s[DataWidth];
  assign quotient_o       = qn_s[DataWidth];
  assign remainder_o      = rem_s[DataWidth];
  assign divide_by_zero_o = dbz_s[DataWidth];

endmodule

// ===== src/bld_checker.sv =====
// Port-level checks for binary_long_division_unit, attached by bind.
// Depends on bld_pkg.

module bld_checker
  import bld_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 valid_i,
  input logic                 stall_o,
  input logic [DataWidth-1:0] dividend_i,
  input logic [DataWidth-1:0] divisor_i,
  input logic                 valid_o,
  input logic                 stall_i,
  input logic [DataWidth-1:0] quotient_o,
  input logic [DataWidth-1:0] remainder_o,
  input logic                 divide_by_zero_o
);

  // A zero divisor yields an all-ones quotient.
  a_dbz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_by_zero_o) |-> (quotient_o == {DataWidth{1'b1}}))
    else $error("divide by zero without all-ones quotient");

  // Input backpressure only comes from a stalled result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a stalled result");

  // While the result is held, a new request cannot be taken.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |-> stall_o)
    else $error("request accepted while result stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(quotient_o) && $stable(remainder_o)
                              && $stable(divide_by_zero_o)))
    else $error("stalled result changed");

  // A request carries known operands.
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !$isunknown({dividend_i, divisor_i}))
    else $error("request fields unknown");

endmodule

bind binary_long_division_unit bld_checker #(
  .DataWidth(DataWidth)
) u_bld_checker (.*);

// ===== dv/bld_quotient_check.sv =====
// Result checker for the binary long division unit: predicts each request's
// quotient, remainder and divide-by-zero flag and compares the responses in order.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_quotient_check
  import bld_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_stall_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_stall_i,
  input  logic [DataWidth-1:0] quotient_i,
  input  logic [DataWidth-1:0] remainder_i,
  input  logic                 divide_by_zero_i,
  output int                   mismatch_count_o,
  output int                   outstanding_o
);

  typedef struct packed {
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
    logic                 by_zero;
  } div_result_t;

  div_result_t predicted_results[$];

  // Restoring division; the partial remainder carries one extra bit so that
  // divisors with the top bit set cannot overflow it.
  function automatic div_result_t long_divide(input logic [DataWidth-1:0] num,
                                              input logic [DataWidth-1:0] den);
    div_result_t res;
    logic [DataWidth:0] part;
    res = '0;
    part = '0;
    if (den == '0) begin
      res.quotient = '1;
      res.remainder = num;
      res.by_zero = 1'b1;
      return res;
    end
    for (int i = DataWidth - 1; i >= 0; i--) begin
      part = {part[DataWidth-1:0], num[i]};
      res.quotient = res.quotient << 1;
      if (part >= {1'b0, den}) begin
        part = part - {1'b0, den};
        res.quotient[0] = 1'b1;
      end
    end
    res.remainder = part[DataWidth-1:0];
    return res;
  endfunction

  function automatic int field_differs(input string field, input logic [DataWidth-1:0] want,
                                       input logic [DataWidth-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    div_result_t want;
    int errs;
    if (!rst_ni) begin
      predicted_results.delete();
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      if (rsp_valid_i && !rsp_stall_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual q=%h r=%h dbz=%b",
                   $time, quotient_i, remainder_i, divide_by_zero_i);
          errs++;
        end else begin
          want = predicted_results.pop_front();
          errs += field_differs("quotient", want.quotient, quotient_i);
          errs += field_differs("remainder", want.remainder, remainder_i);
          errs += field_differs("divide_by_zero", DataWidth'(want.by_zero),
                                DataWidth'(divide_by_zero_i));
        end
      end
      if (req_valid_i && !req_stall_i) begin
        predicted_results.push_back(long_divide(dividend_i, divisor_i));
      end
      mismatch_count_o <= mismatch_count_o + errs;
      outstanding_o <= predicted_results.size();
    end
  end

endmodule

// ===== dv/binary_long_division_unit_tb.sv =====
// Testbench top for the binary long division unit: clock, reset, request and
// response stimulus with random idling, and the final verdict.
// Depends on bld_pkg, bld_quotient_check and the unit itself.
`timescale 1ns / 1ps

module binary_long_division_unit_tb;
  import bld_pkg::*;

  localparam int unsigned DataWidth = DataWidthDefault;
  localparam int RandomRequests = 1430;
  localparam int QuietFrom      = 1250;  // no idling on either side from here on
  localparam int HoldOffAt      = 400;
  localparam int HoldOffCycles  = 300;
  localparam int DrainCycles    = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 req_valid;
  logic                 req_stall;
  logic [DataWidth-1:0] dividend;
  logic [DataWidth-1:0] divisor;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [DataWidth-1:0] quotient;
  logic [DataWidth-1:0] remainder;
  logic                 div_by_zero;

  int mismatches;
  int outstanding;
  bit quiet;
  bit hold_off_go;
  bit hold_off_done;

  always #2 clk = ~clk;

  binary_long_division_unit #(
    .DataWidth(DataWidth)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .valid_i         (req_valid),
    .stall_o         (req_stall),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .valid_o         (rsp_valid),
    .stall_i         (rsp_stall),
    .quotient_o      (quotient),
    .remainder_o     (remainder),
    .divide_by_zero_o(div_by_zero)
  );

  bld_quotient_check #(
    .DataWidth(DataWidth)
  ) u_quotient_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_valid),
    .req_stall_i     (req_stall),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .rsp_valid_i     (rsp_valid),
    .rsp_stall_i     (rsp_stall),
    .quotient_i      (quotient),
    .remainder_i     (remainder),
    .divide_by_zero_i(div_by_zero),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  task automatic offer_request(input logic [DataWidth-1:0] a, input logic [DataWidth-1:0] b);
    @(negedge clk);
    req_valid <= 1'b1;
    dividend <= a;
    divisor <= b;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle_requests(input int cycles);
    @(negedge clk);
    req_valid <= 1'b0;
    dividend <= $urandom;
    divisor <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic hold_responses(input bit stall, input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      rsp_stall <= stall;
    end
  endtask

  task automatic offer_random_request();
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 9))
      3: b = $urandom_range(1, 255);
      4: if ($urandom_range(0, 2) == 0) b = '0;
      5: a = $urandom_range(0, 1023);
      6: b[DataWidth-1] = 1'b1;
      7: begin
        b = $urandom_range(1, 65535);
        a = b * $urandom_range(0, 65535);
      end
      8: case ($urandom_range(0, 2))
        0: b = a;
        1: b = a + 1;
        default: b = a - 1;
      endcase
      9: b = 1 << $urandom_range(0, DataWidth - 1);
      default: ;
    endcase
    offer_request(a, b);
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // response side: random stall bursts, one long hold-off, none at the end
  initial begin
    rsp_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_responses(1'b1, HoldOffCycles);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        hold_responses(1'b1, $urandom_range(1, 18));
      end else begin
        hold_responses(1'b0, quiet ? 1 : $urandom_range(1, 30));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_valid = 1'b0;
    dividend = '0;
    divisor = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero divisor, extremes, divisor above dividend, top bit set in divisor
    offer_request('0, '0);
    offer_request('1, '0);
    offer_request(32'd12345, '0);
    offer_request('0, 32'd1);
    offer_request(32'd1, 32'd1);
    offer_request('1, 32'd1);
    offer_request('1, '1);
    offer_request(32'd1, '1);
    offer_request('1, 32'hffff_fffe);
    offer_request(32'hffff_fffe, '1);
    offer_request('1, 32'h8000_0001);
    offer_request(32'h8000_0000, 32'h8000_0000);
    offer_request(32'h8000_0000, 32'd1);
    offer_request('1, 32'h8000_0000);
    offer_request(32'd7, 32'd3);
    offer_request(32'd100, 32'd7);
    offer_request(32'd5, 32'd9);
    offer_request(32'hdead_beef, 32'h10);
    offer_request(32'h5555_5555, 32'haaaa_aaaa);
    offer_request(32'haaaa_aaaa, 32'h5555_5555);

    // let the pipeline drain completely once
    idle_requests(1);
    wait (outstanding == 0);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == HoldOffAt) hold_off_go = 1'b1;
      if (n == QuietFrom) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) idle_requests($urandom_range(1, 18));
      offer_random_request();
    end

    idle_requests(1);
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
